// ===== hdl/l2sc_pkg.sv =====
// ----------------------------------------------------------------------------
// l2sc_pkg: shared types and constants
// Parse phase codes, NAL type codes and the result descriptor that the
// parser hands to the emitter.
// ----------------------------------------------------------------------------
package l2sc_pkg;

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_S_LEN      = 4'd1;
  localparam logic [3:0] PH_NAL_HEAD   = 4'd2;
  localparam logic [3:0] PH_NAL_BODY   = 4'd3;
  localparam logic [3:0] PH_R_HEAD     = 4'd4;
  localparam logic [3:0] PH_R_SPSCNT   = 4'd5;
  localparam logic [3:0] PH_R_LEN      = 4'd6;
  localparam logic [3:0] PH_R_PPSCNT   = 4'd7;
  localparam logic [3:0] PH_R_AFTERPPS = 4'd8;
  localparam logic [3:0] PH_R_EXT      = 4'd9;
  localparam logic [3:0] PH_R_DONE     = 4'd10;

  localparam logic [3:0] NAL_ANY     = 4'd0;
  localparam logic [3:0] NAL_SPS     = 4'd7;
  localparam logic [3:0] NAL_PPS     = 4'd8;
  localparam logic [3:0] NAL_SPS_EXT = 4'd13;

  localparam logic [7:0] PROFILE_HIGH = 8'd100;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_RECORD = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Results caused by one input item.
  typedef struct packed {
    logic       start_code;
    logic       data;
    logic [7:0] data_byte;
    logic       status;
    logic       bad;
  } l2sc_desc_t;

endpackage

// ===== hdl/h264_length_prefix_to_start_code.sv =====
// ----------------------------------------------------------------------------
// h264_length_prefix_to_start_code: length prefix to start code converter
// Converts length-prefixed NAL units or a decoder configuration record
// into a start-code byte stream, closing each unit with a status item.
// ----------------------------------------------------------------------------
// The input channel takes one byte per item, with in_last on the final byte
// of a unit. The result channel gives data bytes (out_kind low) and, for
// each in_last, one status item with out_unit_status set if the unit was
// invalid; the consumer then drops everything given for that unit.
// cfg_unit_mode selects sample or record parsing; it is always ready and
// takes effect at the next unit's first byte.
// Each item is parsed in the cycle it is accepted and its results appear
// from the result register the next cycle, one per cycle while the
// receiver is ready. An item causes zero to six results, so the input
// runs at one item per cycle while the receiver is ready, except while an
// item's extra results are sent: the start code of a NAL header, and the
// status item of a closing byte that also gives a data byte or start code.
// An item that causes no result never stalls the input.
// Reset returns the parser to the start of a unit in sample mode and
// empties the result register. When the receiver stalls, the current
// result holds and the input stalls once the pending item's results
// are not yet all taken.
// ----------------------------------------------------------------------------
module h264_length_prefix_to_start_code (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_unit_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_unit_status,
  output logic       out_run_last
);
  import l2sc_pkg::*;

  l2sc_desc_t desc;
  logic       free;
  logic       take;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign take      = in_valid && free;

  l2sc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_unit_mode (cfg_unit_mode),
    .item_take     (take),
    .item_byte     (in_byte),
    .item_last     (in_last),
    .desc          (desc)
  );

  l2sc_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (take),
    .desc            (desc),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_unit_status (out_unit_status),
    .out_run_last    (out_run_last)
  );

endmodule

// ===== hdl/l2sc_parser.sv =====
// ----------------------------------------------------------------------------
// l2sc_parser: unit parser
// Holds the parse state of the current unit and, for each accepted item,
// updates it and describes the results that the item causes.
// ----------------------------------------------------------------------------
module l2sc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_unit_mode,
  input  logic                item_take,
  input  logic [7:0]          item_byte,
  input  logic                item_last,
  output l2sc_pkg::l2sc_desc_t desc
);
  import l2sc_pkg::*;

  logic        mode_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  sets_r, sets_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic [7:0]  prof_r, prof_nxt;
  logic        err_r, err_nxt;

  logic [3:0]  ph;
  logic [31:0] acc_eff;
  logic [2:0]  fbi_eff;
  logic        finish;
  logic [7:0]  sets_dec;
  logic        ok;
  logic [7:0]  b;

  always_comb begin
    b         = item_byte;
    phase_nxt = phase_r;
    fbi_nxt   = fbi_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    sets_nxt  = sets_r;
    exp_nxt   = exp_r;
    prof_nxt  = prof_r;
    err_nxt   = err_r;
    desc      = '0;
    finish    = 1'b0;
    ph        = phase_r;
    acc_eff   = acc_r;
    fbi_eff   = fbi_r;
    sets_dec  = sets_r - 8'd1;
    ok        = 1'b0;

    if (!err_r) begin
      if (phase_r == PH_START && mode_r == MODE_RECORD) begin
        ph = PH_START;
        if (b != 8'd1) begin
          err_nxt = 1'b1;
        end else begin
          phase_nxt = PH_R_HEAD;
          fbi_nxt   = 3'd1;
        end
      end else begin
        if (phase_r == PH_START) begin
          ph      = PH_S_LEN;
          acc_eff = '0;
          fbi_eff = '0;
          exp_nxt = NAL_ANY;
          phase_nxt = PH_S_LEN;
        end
        case (ph)
          PH_S_LEN: begin
            acc_nxt = {acc_eff[23:0], b};
            fbi_nxt = fbi_eff + 3'd1;
            if (fbi_eff == 3'd3) begin
              fbi_nxt = '0;
              if (acc_nxt == '0) err_nxt = 1'b1;
              else phase_nxt = PH_NAL_HEAD;
            end
          end
          PH_R_LEN: begin
            acc_nxt = {16'd0, acc_eff[7:0], b};
            if (fbi_eff == 3'd0) begin
              fbi_nxt = 3'd1;
            end else begin
              fbi_nxt = '0;
              if (acc_nxt == '0) err_nxt = 1'b1;
              else phase_nxt = PH_NAL_HEAD;
            end
          end
          PH_NAL_HEAD: begin
            if (b[7] || (exp_r != NAL_ANY && {3'd0, b[4:0]} != {4'd0, exp_r})) begin
              err_nxt = 1'b1;
            end else begin
              desc.start_code = 1'b1;
              desc.data       = 1'b1;
              desc.data_byte  = b;
              left_nxt        = acc_r - 32'd1;
              if (left_nxt == '0) finish = 1'b1;
              else phase_nxt = PH_NAL_BODY;
            end
          end
          PH_NAL_BODY: begin
            desc.data      = 1'b1;
            desc.data_byte = b;
            left_nxt       = left_r - 32'd1;
            if (left_nxt == '0) finish = 1'b1;
          end
          PH_R_HEAD: begin
            if (fbi_r == 3'd1) prof_nxt = b;
            if (fbi_r >= 3'd4) begin
              if (b != 8'hff) err_nxt = 1'b1;
              else phase_nxt = PH_R_SPSCNT;
            end
            fbi_nxt = fbi_r + 3'd1;
          end
          PH_R_SPSCNT: begin
            if (b[7:5] != 3'b111 || b[4:0] == 5'd0) begin
              err_nxt = 1'b1;
            end else begin
              sets_nxt  = {3'd0, b[4:0]};
              exp_nxt   = NAL_SPS;
              phase_nxt = PH_R_LEN;
              fbi_nxt   = '0;
              acc_nxt   = '0;
            end
          end
          PH_R_PPSCNT: begin
            if (b == 8'd0) begin
              err_nxt = 1'b1;
            end else begin
              sets_nxt  = b;
              exp_nxt   = NAL_PPS;
              phase_nxt = PH_R_LEN;
              fbi_nxt   = '0;
              acc_nxt   = '0;
            end
          end
          PH_R_AFTERPPS: begin
            if (prof_r != PROFILE_HIGH || b[7:2] != 6'h3f) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt = PH_R_EXT;
              fbi_nxt   = 3'd1;
            end
          end
          PH_R_EXT: begin
            if (fbi_r < 3'd3) begin
              if (b[7:3] != 5'h1f) err_nxt = 1'b1;
              else fbi_nxt = fbi_r + 3'd1;
            end else if (b == 8'd0) begin
              phase_nxt = PH_R_DONE;
            end else begin
              sets_nxt  = b;
              exp_nxt   = NAL_SPS_EXT;
              phase_nxt = PH_R_LEN;
              fbi_nxt   = '0;
              acc_nxt   = '0;
            end
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase

        if (finish) begin
          if (exp_r == NAL_ANY) begin
            phase_nxt = PH_S_LEN;
            fbi_nxt   = '0;
            acc_nxt   = '0;
          end else begin
            sets_nxt = sets_dec;
            if (sets_dec != 8'd0) begin
              phase_nxt = PH_R_LEN;
              fbi_nxt   = '0;
              acc_nxt   = '0;
            end else if (exp_r == NAL_SPS) begin
              phase_nxt = PH_R_PPSCNT;
            end else if (exp_r == NAL_PPS) begin
              phase_nxt = PH_R_AFTERPPS;
            end else begin
              phase_nxt = PH_R_DONE;
            end
          end
        end
      end
    end

    if (item_last) begin
      ok = !err_nxt && ((phase_nxt == PH_S_LEN && fbi_nxt == 3'd0) ||
                        phase_nxt == PH_R_AFTERPPS || phase_nxt == PH_R_DONE);
      desc.status = 1'b1;
      desc.bad    = !ok;
      phase_nxt   = PH_START;
      fbi_nxt     = '0;
      acc_nxt     = '0;
      left_nxt    = '0;
      sets_nxt    = '0;
      exp_nxt     = NAL_ANY;
      prof_nxt    = '0;
      err_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SAMPLE;
      phase_r <= PH_START;
      fbi_r   <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      sets_r  <= '0;
      exp_r   <= NAL_ANY;
      prof_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_unit_mode;
      if (item_take) begin
        phase_r <= phase_nxt;
        fbi_r   <= fbi_nxt;
        acc_r   <= acc_nxt;
        left_r  <= left_nxt;
        sets_r  <= sets_nxt;
        exp_r   <= exp_nxt;
        prof_r  <= prof_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ===== hdl/l2sc_emitter.sv =====
// ----------------------------------------------------------------------------
// l2sc_emitter: result sequencer
// Registers the result descriptor of one item and delivers its results
// one per cycle when out_ready is high: start code, data byte, status item.
// ----------------------------------------------------------------------------
module l2sc_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  l2sc_pkg::l2sc_desc_t desc,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_unit_status,
  output logic                 out_run_last
);
  import l2sc_pkg::*;

  l2sc_desc_t desc_r;
  logic       vld_r;
  logic [2:0] step_r, step_nxt;
  logic [2:0] count;
  logic [2:0] pos;
  logic       final_step;
  logic       has_results;

  assign count = (desc_r.start_code ? 3'd4 : 3'd0) + {2'd0, desc_r.data} +
                 {2'd0, desc_r.status};
  assign final_step  = (step_r == count - 3'd1);
  assign free        = !vld_r || (out_ready && final_step);
  assign has_results = desc.start_code || desc.data || desc.status;
  assign out_valid   = vld_r;
  assign out_run_last = final_step;

  always_comb begin
    pos             = desc_r.start_code ? step_r - 3'd4 : step_r;
    out_kind        = KIND_DATA;
    out_byte        = '0;
    out_unit_status = 1'b0;
    if (desc_r.start_code && step_r < 3'd4) begin
      out_byte = (step_r == 3'd3) ? 8'd1 : 8'd0;
    end else if (desc_r.data && pos == 3'd0) begin
      out_byte = desc_r.data_byte;
    end else begin
      out_kind        = KIND_STATUS;
      out_unit_status = desc_r.bad;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (vld_r && out_ready) step_nxt = step_r + 3'd1;
    if (load) step_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
      if (load) vld_r <= has_results;
      else if (out_ready && final_step) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc_r <= desc;
  end

endmodule
